@@ rtl/core/oerm_pkg.sv @@
// Package for the orbit rotation matrix block: widths, CORDIC constants, beat types.
// No dependencies.
package oerm_pkg;
   localparam int CordicStages = 14;
   localparam int AtanEntries  = 24;
   localparam int ZW = 36;

   localparam logic signed [ZW-1:0] GainQ30   = 36'sd652032874;
   localparam logic signed [ZW-1:0] PiQ30     = 36'sd3373259426;
   localparam logic signed [ZW-1:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [ZW-1:0] TwoPiQ30  = 36'sd6746518852;
   localparam logic signed [15:0]   OneQ14    = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] periapsis_angle;
      logic signed [15:0] inclination_angle;
      logic signed [15:0] node_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   // One rotator's working values inside the chain.
   typedef struct packed {
      logic signed [ZW-1:0] x;
      logic signed [ZW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 neg;
   } rot_type;

   typedef struct packed {
      logic    vld;
      rot_type r0;
      rot_type r1;
      rot_type r2;
   } cell_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int k);
      logic [31:0] v;
      begin
         case (k)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;   3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;   9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;  15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;  19: v = 32'h000007FF;
            20: v = 32'h000003FF;  21: v = 32'h000001FF;
            22: v = 32'h000000FF;  23: v = 32'h0000007F;
            default: v = 32'h0;
         endcase
         return $signed({4'b0, v});
      end
   endfunction
endpackage

@@ rtl/core/oerm_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on oerm_pkg.
interface oerm_req_if;
   logic              valid;
   logic              ready;
   oerm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface oerm_rsp_if;
   logic              valid;
   logic              ready;
   oerm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/oerm_fold.sv @@
// Angle widening and quadrant folding ahead of the CORDIC chain, registered.
// Depends on oerm_pkg.
module oerm_fold (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [15:0]       angle,
   output oerm_pkg::rot_type        rot_ff
);
   oerm_pkg::rot_type rot_in;
   logic signed [oerm_pkg::ZW-1:0] z;

   always_comb begin
      z = {{(oerm_pkg::ZW-34){angle[15]}}, angle, 18'b0};
      if (z > oerm_pkg::PiQ30) z = z - oerm_pkg::TwoPiQ30;
      if (z < -oerm_pkg::PiQ30) z = z + oerm_pkg::TwoPiQ30;
      rot_in.neg = 1'b0;
      if (z > oerm_pkg::HalfPiQ30) begin
         z = z - oerm_pkg::PiQ30;
         rot_in.neg = 1'b1;
      end else if (z < -oerm_pkg::HalfPiQ30) begin
         z = z + oerm_pkg::PiQ30;
         rot_in.neg = 1'b1;
      end
      rot_in.x = oerm_pkg::GainQ30;
      rot_in.y = '0;
      rot_in.z = z;
   end

   always_ff @(posedge clock) begin
      if (enable) rot_ff <= rot_in;
   end
endmodule

@@ rtl/core/oerm_cell.sv @@
// One CORDIC micro-rotation cell for all three angles, with its pipeline register.
// Depends on oerm_pkg.
module oerm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [4:0]           stage,
   input  oerm_pkg::cell_type   cell_i,
   output oerm_pkg::cell_type   cell_ff
);
   oerm_pkg::cell_type cell_in;

   function automatic oerm_pkg::rot_type rotate(input oerm_pkg::rot_type r,
                                               input logic [4:0] k);
      oerm_pkg::rot_type o;
      logic signed [oerm_pkg::ZW-1:0] dx, dy, a;
      begin
         dx = r.y >>> k;
         dy = r.x >>> k;
         a  = oerm_pkg::atan_q30(int'(k));
         o = r;
         if (!r.z[oerm_pkg::ZW-1]) begin
            o.x = r.x - dx;  o.y = r.y + dy;  o.z = r.z - a;
         end else begin
            o.x = r.x + dx;  o.y = r.y - dy;  o.z = r.z + a;
         end
         return o;
      end
   endfunction

   always_comb begin
      cell_in.vld = cell_i.vld;
      cell_in.r0  = rotate(cell_i.r0, stage);
      cell_in.r1  = rotate(cell_i.r1, stage);
      cell_in.r2  = rotate(cell_i.r2, stage);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (enable) begin
         cell_ff.vld <= cell_in.vld;
      end
      if (enable) begin
         cell_ff.r0 <= cell_in.r0;
         cell_ff.r1 <= cell_in.r1;
         cell_ff.r2 <= cell_in.r2;
      end
   end
endmodule

@@ rtl/core/oerm_matrix.sv @@
// Rounds sine/cosine to Q18, forms the rotation matrix products and saturates.
// Three pipeline stages; depends on oerm_pkg.
module oerm_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  oerm_pkg::cell_type   cell_i,
   output logic                 vld_ff,
   output oerm_pkg::rsp_type    rsp_ff
);
   typedef logic signed [19:0] q18_type;
   typedef logic signed [39:0] p2_type;
   typedef logic signed [63:0] q54_type;

   // Stage A: rounded sine and cosine.
   q18_type s1_ff, c1_ff, s2_ff, c2_ff, s3_ff, c3_ff;
   logic    va_ff;
   // Stage B: double products in Q36.
   p2_type  c3c2_ff, s3c2_ff, c3s2_ff, s2c1_ff, s2s1_ff, s3s2_ff;
   p2_type  s3s1_ff, s3c1_ff, c3s1_ff, c3c1_ff, c2_q36_ff;
   q18_type c1b_ff, s1b_ff;
   logic    vb_ff;

   function automatic q18_type narrow(input logic signed [oerm_pkg::ZW-1:0] v,
                                      input logic neg);
      logic signed [oerm_pkg::ZW-1:0] t;
      begin
         t = neg ? -v : v;
         t = (t + oerm_pkg::ZW'(2048)) >>> 12;
         return t[19:0];
      end
   endfunction

   function automatic logic signed [15:0] to_q14(input q54_type v);
      q54_type r;
      begin
         r = (v + (64'sd1 <<< 39)) >>> 40;
         if (r > 64'sd16384) r = 64'sd16384;
         if (r < -64'sd16384) r = -64'sd16384;
         return r[15:0];
      end
   endfunction

   function automatic q54_type up(input p2_type v);
      return {{6{v[39]}}, v, 18'b0};
   endfunction

   function automatic q54_type tri3(input p2_type a, input q18_type b);
      return 64'(a) * 64'(b);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= cell_i.vld;
         vb_ff <= va_ff;
         vld_ff <= vb_ff;
      end
      if (enable) begin
         s1_ff <= narrow(cell_i.r0.y, cell_i.r0.neg);
         c1_ff <= narrow(cell_i.r0.x, cell_i.r0.neg);
         s2_ff <= narrow(cell_i.r1.y, cell_i.r1.neg);
         c2_ff <= narrow(cell_i.r1.x, cell_i.r1.neg);
         s3_ff <= narrow(cell_i.r2.y, cell_i.r2.neg);
         c3_ff <= narrow(cell_i.r2.x, cell_i.r2.neg);

         c3c2_ff <= c3_ff * c2_ff;  s3c2_ff <= s3_ff * c2_ff;
         c3s2_ff <= c3_ff * s2_ff;  s2c1_ff <= s2_ff * c1_ff;
         s2s1_ff <= s2_ff * s1_ff;  s3s2_ff <= s3_ff * s2_ff;
         s3s1_ff <= s3_ff * s1_ff;  s3c1_ff <= s3_ff * c1_ff;
         c3s1_ff <= c3_ff * s1_ff;  c3c1_ff <= c3_ff * c1_ff;
         c2_q36_ff <= {{2{c2_ff[19]}}, c2_ff, 18'b0};
         c1b_ff <= c1_ff;  s1b_ff <= s1_ff;

         rsp_ff.m00 <= to_q14(tri3(c3c2_ff, c1b_ff) - up(s3s1_ff));
         rsp_ff.m01 <= to_q14(-up(c3s2_ff));
         rsp_ff.m02 <= to_q14(tri3(c3c2_ff, s1b_ff) + up(s3c1_ff));
         rsp_ff.m10 <= to_q14(up(s2c1_ff));
         rsp_ff.m11 <= to_q14(up(c2_q36_ff));
         rsp_ff.m12 <= to_q14(up(s2s1_ff));
         rsp_ff.m20 <= to_q14(-tri3(s3c2_ff, c1b_ff) - up(c3s1_ff));
         rsp_ff.m21 <= to_q14(up(s3s2_ff));
         rsp_ff.m22 <= to_q14(-tri3(s3c2_ff, s1b_ff) + up(c3c1_ff));
      end
   end
endmodule

@@ rtl/core/orbit_euler_rotation_matrix.sv @@
// Orbit rotation matrix R = R3*R2*R1 (Y-Z-Y Euler angles) via pipelined CORDIC.
// Throughput: one beat per cycle; the pipeline stalls as a whole when the
// response is not taken. Synchronous active-high reset empties the pipeline.
// Depends on oerm_pkg, oerm_if, oerm_fold, oerm_cell and oerm_matrix.
module orbit_euler_rotation_matrix (
   input  logic          clock,
   input  logic          reset,
   oerm_req_if.sink      req,
   oerm_rsp_if.source    rsp
);
   localparam int N = (oerm_pkg::CordicStages < oerm_pkg::AtanEntries) ?
                      oerm_pkg::CordicStages : oerm_pkg::AtanEntries;

   logic enable;
   logic vf_ff;
   oerm_pkg::cell_type chain [0:N];
   logic mvld;

   // The whole pipeline holds still while the output beat waits.
   assign enable    = !rsp.valid || rsp.ready;
   assign req.ready = enable;
   assign rsp.valid = mvld;

   oerm_fold u_fold0 (.clock, .enable, .angle(req.data.periapsis_angle),
                      .rot_ff(chain[0].r0));
   oerm_fold u_fold1 (.clock, .enable, .angle(req.data.inclination_angle),
                      .rot_ff(chain[0].r1));
   oerm_fold u_fold2 (.clock, .enable, .angle(req.data.node_angle),
                      .rot_ff(chain[0].r2));

   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else if (enable) vf_ff <= req.valid;
   end
   assign chain[0].vld = vf_ff;

   for (genvar k = 0; k < N; k++) begin : g_cell
      oerm_cell u_cell (.clock, .reset, .enable, .stage(5'(k)),
                        .cell_i(chain[k]), .cell_ff(chain[k+1]));
   end

   oerm_matrix u_matrix (.clock, .reset, .enable, .cell_i(chain[N]),
                         .vld_ff(mvld), .rsp_ff(rsp.data));

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response beat changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready inconsistent with output stall");
   a_diag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.m11 <= oerm_pkg::OneQ14 && rsp.data.m11 >= -oerm_pkg::OneQ14)
      else $error("matrix element out of range");
`endif
endmodule

@@ dv/orbit_euler_rotation_matrix_tb.sv @@
// Testbench for the orbit rotation matrix block: directed and random angle triples,
// with a bit-exact CORDIC and matrix predictor checked against every response beat.
// Depends on oerm_pkg, oerm_if and orbit_euler_rotation_matrix.
`timescale 1ns / 100ps

module orbit_euler_rotation_matrix_tb;
   localparam int  Stages  = oerm_pkg::CordicStages;
   localparam int  Latency = oerm_pkg::CordicStages + 4;
   localparam longint One54 = 64'sd1 << 39;

   logic clock = 1'b0;
   logic reset = 1'b1;

   oerm_req_if req_if ();
   oerm_rsp_if rsp_if ();

   orbit_euler_rotation_matrix u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #10 clock = ~clock;

   oerm_pkg::rsp_type matrix_q[$];
   int      mismatches = 0;
   bit      rsp_stall_on = 1'b1;

   longint atan_tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   // Sine and cosine of a Q4.12 angle, both in Q18.
   task automatic sin_cos_q18(input logic signed [15:0] ang, output longint s,
                              output longint c);
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(ang) * 262144;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = 1'b1;
      end
      for (int k = 0; k < Stages && k < 24; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[k];
         end else begin
            x += dx; y -= dy; z += atan_tab[k];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = (y + 2048) >>> 12;
      c = (x + 2048) >>> 12;
   endtask

   function automatic logic signed [15:0] round_q14(input longint v);
      longint r;
      r = (v + One54) >>> 40;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   task automatic predict_matrix(input oerm_pkg::req_type a, output oerm_pkg::rsp_type m);
      longint s1, c1, s2, c2, s3, c3;
      longint up;
      up = 262144;
      sin_cos_q18(a.periapsis_angle, s1, c1);
      sin_cos_q18(a.inclination_angle, s2, c2);
      sin_cos_q18(a.node_angle, s3, c3);
      m.m00 = round_q14(c3 * c2 * c1 - s3 * s1 * up);
      m.m01 = round_q14(-(c3 * s2) * up);
      m.m02 = round_q14(c3 * c2 * s1 + s3 * c1 * up);
      m.m10 = round_q14(s2 * c1 * up);
      m.m11 = round_q14(c2 * up * 262144);
      m.m12 = round_q14(s2 * s1 * up);
      m.m20 = round_q14(-(s3 * c2 * c1) - c3 * s1 * up);
      m.m21 = round_q14(s3 * s2 * up);
      m.m22 = round_q14(-(s3 * c2 * s1) + c3 * c1 * up);
   endtask

   // Drives one request beat and holds it until it is taken.
   task automatic send_angles(input oerm_pkg::req_type a);
      oerm_pkg::rsp_type m;
      predict_matrix(a, m);
      req_if.valid <= 1'b1;
      req_if.data  <= a;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      matrix_q.insert(matrix_q.size(), m);
      @(negedge clock);
   endtask

   task automatic idle_req(input int n);
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_triple(input int p, input int i, input int o);
      oerm_pkg::req_type a;
      a.periapsis_angle   = 16'(p);
      a.inclination_angle = 16'(i);
      a.node_angle        = 16'(o);
      send_angles(a);
   endtask

   function automatic int rand_angle();
      case ($urandom_range(0, 9))
         0:       return int'($urandom_range(0, 65535)) - 32768;
         1:       return $urandom_range(0, 1) ? 25736 : -25736;
         2:       return int'($urandom_range(0, 12)) - 6;
         default: return int'($urandom_range(0, 51472)) - 25736;
      endcase
   endfunction

   task automatic wait_drained();
      idle_req(1);
      while (matrix_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      int ang[] = '{0, 25736, -25736, 32767, -32768, 6434, -6434, 12868, -12868,
                    6433, 6435, 1, -1};
      foreach (ang[n]) send_triple(ang[n], 0, 0);
      send_triple(0, 6434, 0);
      send_triple(0, -6434, 0);
      send_triple(0, 12868, 0);
      send_triple(0, 0, 6434);
      send_triple(0, 0, -12868);
      send_triple(3217, 3217, 3217);
      send_triple(-32768, 32767, -32768);
      send_triple(32767, -32768, 32767);
      send_triple(16'h5555, 16'hAAAA, 16'h5555);
      send_triple(16'hAAAA, 16'h5555, 16'hAAAA);
   endtask

   // Bursts of random length, most of them followed by a random gap.
   task automatic test_random(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int n = 0; n < burst && count > 0; n++, count--)
            send_triple(rand_angle(), rand_angle(), rand_angle());
         if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 8));
      end
   endtask

   // Back-to-back beats with the receiver always ready.
   task automatic test_full_rate();
      rsp_stall_on = 1'b0;
      for (int n = 0; n < 100; n++)
         send_triple(rand_angle(), rand_angle(), rand_angle());
      wait_drained();
      rsp_stall_on = 1'b1;
   endtask

   // Receiver stall pattern: stretches of stalling and of free flow.
   initial begin
      int phase;
      rsp_if.ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (!rsp_stall_on || (phase % 200) < 60) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      oerm_pkg::rsp_type want;
      oerm_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (matrix_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response beat %h", got);
         end else begin
            want = matrix_q.pop_front();
            if (want !== got) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Matrix mismatch, expected %0d %0d %0d / %0d %0d %0d / %0d %0d %0d",
                           want.m00, want.m01, want.m02, want.m10, want.m11,
                           want.m12, want.m20, want.m21, want.m22);
                  $display("                 actual   %0d %0d %0d / %0d %0d %0d / %0d %0d %0d",
                           got.m00, got.m01, got.m02, got.m10, got.m11,
                           got.m12, got.m20, got.m21, got.m22);
               end
            end
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      wait_drained();
      test_random(350);
      wait_drained();
      test_full_rate();
      test_random(350);
      wait_drained();
      repeat (Latency * 4) @(negedge clock);
      if (mismatches == 0 && matrix_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/oerm_pkg.sv
rtl/core/oerm_if.sv
rtl/core/oerm_fold.sv
rtl/core/oerm_cell.sv
rtl/core/oerm_matrix.sv
rtl/core/orbit_euler_rotation_matrix.sv
dv/orbit_euler_rotation_matrix_tb.sv
